>>> hw/rtl/pds_pkg.sv
// Shared types and constants for the positional deque store.
`default_nettype none

package pds_pkg;

  localparam int WORD_W      = 64;
  localparam int POS_W       = 5;
  localparam int CNT_OUT_W   = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 200;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT,
    FN_PUSH_BACK,
    FN_POP_FRONT,
    FN_POP_BACK,
    FN_INSERT,
    FN_REMOVE,
    FN_READ_AT,
    FN_CLEAR
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_RANGE
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_RDRES,
    S_REF_A,
    S_REF_B,
    S_REF_C,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    func_t               func;
    logic [WORD_W-1:0]   data_word;
    logic [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]    result_word;
    logic [CNT_OUT_W-1:0] element_count;
    logic [WORD_W-1:0]    front_word;
    logic [WORD_W-1:0]    back_word;
    status_t              status;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/pds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/pds_ctrl.sv
// Sequencer: decodes a request, shifts words through the RAM, refreshes front and back.
`default_nettype none

module pds_ctrl
  import pds_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  input  wire req_t              req,
  output logic                   req_ready,
  output logic                   res_valid,
  output result_t                res,
  input  wire logic              res_ready,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [WORD_W-1:0]      mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  wire logic [WORD_W-1:0] mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     tgt_r, tgt_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic              rmore_r, rmore_nxt;
  logic              wpend_r, wpend_nxt;
  logic              cap_r, cap_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] result_r, result_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] ins_x;
  logic [XW-1:0] rem_x;
  logic          full;
  logic          empty;

  assign pos_x = XW'(req.position);
  assign cnt_x = XW'(cnt_r);
  assign full  = (cnt_r == CW'(CAPACITY));
  assign empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rmore_r  <= 1'b0;
      wpend_r  <= 1'b0;
      cap_r    <= 1'b0;
      front_r  <= '0;
      back_r   <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rmore_r  <= rmore_nxt;
      wpend_r  <= wpend_nxt;
      cap_r    <= cap_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r    <= tgt_nxt;
    rptr_r   <= rptr_nxt;
    wptr_r   <= wptr_nxt;
    word_r   <= word_nxt;
    result_r <= result_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    rptr_nxt   = rptr_r;
    wptr_nxt   = wptr_r;
    rmore_nxt  = rmore_r;
    wpend_nxt  = wpend_r;
    cap_nxt    = cap_r;
    word_nxt   = word_r;
    result_nxt = result_r;
    status_nxt = status_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    mem_we     = 1'b0;
    mem_waddr  = wptr_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    ins_x      = cnt_x;
    rem_x      = '0;

    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          result_nxt = '0;
          status_nxt = ST_OK;
          word_nxt   = req.data_word;
          wpend_nxt  = 1'b0;
          cap_nxt    = 1'b0;
          unique case (req.func)
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
              if (req.func == FN_PUSH_FRONT) begin
                ins_x = '0;
              end else if (req.func == FN_INSERT && pos_x < cnt_x) begin
                ins_x = pos_x;
              end
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                tgt_nxt   = AW'(ins_x);
                rptr_nxt  = AW'(cnt_x - XW'(1));
                rmore_nxt = 1'b1;
                state_nxt = (ins_x == cnt_x) ? S_PUT : S_UP;
              end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_REMOVE: begin
              if (req.func == FN_POP_BACK) begin
                rem_x = cnt_x - XW'(1);
              end else if (req.func == FN_REMOVE) begin
                rem_x = pos_x;
              end
              if (empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else if (req.func == FN_REMOVE && pos_x >= cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                // read the removed word first, then pull the tail down one place
                mem_raddr = AW'(rem_x);
                rptr_nxt  = AW'(rem_x + XW'(1));
                rmore_nxt = (rem_x + XW'(1)) < cnt_x;
                cap_nxt   = 1'b1;
                state_nxt = S_DOWN;
              end
            end
            FN_READ_AT: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                mem_raddr = AW'(pos_x);
                state_nxt = S_RDRES;
              end
            end
            FN_CLEAR: begin
              cnt_nxt   = '0;
              front_nxt = '0;
              back_nxt  = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_UP: begin
        // read the next word down while writing the word read last cycle one place up
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        if (rmore_r) begin
          mem_raddr = rptr_r;
          wpend_nxt = 1'b1;
          wptr_nxt  = rptr_r + AW'(1);
          if (rptr_r == tgt_r) begin
            rmore_nxt = 1'b0;
          end else begin
            rptr_nxt = rptr_r - AW'(1);
          end
        end else begin
          wpend_nxt = 1'b0;
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = word_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_REF_A;
      end

      S_DOWN: begin
        if (cap_r) begin
          result_nxt = mem_rdata;
          cap_nxt    = 1'b0;
        end
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        if (rmore_r) begin
          mem_raddr = rptr_r;
          wpend_nxt = 1'b1;
          wptr_nxt  = rptr_r - AW'(1);
          rptr_nxt  = rptr_r + AW'(1);
          rmore_nxt = (XW'(rptr_r) + XW'(2)) <= cnt_x;
        end else begin
          wpend_nxt = 1'b0;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_REF_A;
        end
      end

      S_RDRES: begin
        result_nxt = mem_rdata;
        state_nxt  = S_DONE;
      end

      S_REF_A: begin
        if (empty) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          mem_raddr = '0;
          state_nxt = S_REF_B;
        end
      end

      S_REF_B: begin
        front_nxt = mem_rdata;
        mem_raddr = AW'(cnt_x - XW'(1));
        state_nxt = S_REF_C;
      end

      S_REF_C: begin
        back_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = '{
    result_word:   result_r,
    element_count: CNT_OUT_W'(cnt_r),
    front_word:    front_r,
    back_word:     back_r,
    status:        status_r
  };

endmodule

`default_nettype wire

>>> hw/rtl/positional_deque_store.sv
// Top level of the positional deque store: stream ports, output register, RAM and sequencer.
//
//  channel | dir | beat fields (tdata, low bit first)
//  in_*    | in  | func[2:0] data_word[66:3] position[71:67]
//  out_*   | out | result_word[63:0] element_count[68:64] front_word[132:69]
//          |     | back_word[196:133] status[198:197] zero[199]
//
// Clear and rejected requests skip the RAM; read_at reads one word; push_back or append
// writes at count; push_front or insert at p below count first shifts words p..count-1 up;
// pop or remove at p shifts words above p down; front and back are then re-read unless empty.
// The tail shift moves one word per cycle through the single-port-pair RAM.
// Reset: synchronous, active low; the list comes up empty, RAM content is not cleared.
// A finished beat waits in the output register while the next input beat is taken.
`default_nettype none

module positional_deque_store
  import pds_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // func, data_word, position
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // result_word, element_count, front_word, back_word, status, zero pad
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  req_t              req;
  result_t           res;
  logic              res_valid;
  logic              res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic    out_valid_r;
  result_t out_data_r;

  assign req.func      = func_t'(in_tdata[2:0]);
  assign req.data_word = in_tdata[66:3];
  assign req.position  = in_tdata[71:67];

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.status, out_data_r.back_word, out_data_r.front_word,
                       out_data_r.element_count, out_data_r.result_word};

  pds_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pds_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pds_checker.sv
// Port-level checks for the positional deque store, bound to the top level.
`default_nettype none

module pds_checker
  import pds_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CNT_OUT_W-1:0] cnt;
  logic [1:0]           st;

  assign cnt = out_tdata[68:64];
  assign st  = out_tdata[198:197];

  // an accepted request always drops input ready before the next can be taken
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cnt == '0 |-> out_tdata[132:69] == '0 && out_tdata[196:133] == '0)
    else $error("empty list reports nonzero front or back");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> cnt == '0 && out_tdata[63:0] == '0)
    else $error("empty status with elements or a result word");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL && CAPACITY < 32 |->
      cnt == CNT_OUT_W'(CAPACITY) && out_tdata[63:0] == '0)
    else $error("full status on a list that is not full");

endmodule

bind positional_deque_store pds_checker #(.CAPACITY(CAPACITY)) u_pds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
